### sv/mwsc_pkg.sv
// Shared widths, register codes and result type for the max window sum counter.
`timescale 1ns / 1ps

package mwsc_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W = 28;
  localparam int COUNT_W = 23;

  localparam int ROWS_REG_W = 13;
  localparam int COLS_REG_W = 11;
  localparam int WIN_REG_W = 7;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_INDEX_W = 2;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_MAX_ROWS = 4096;

  localparam int QUEUE_DEPTH = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_ROWS   = 2'd0,
    REG_GRID_COLS   = 2'd1,
    REG_WINDOW_SIZE = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] max_sum;
    logic [COUNT_W-1:0] tie_count;
  } result_t;

endpackage

### sv/max_window_sum_counter.sv
// Max window sum counter top: largest square window sum per frame and its tie count.
`timescale 1ns / 1ps

// Samples arrive in raster order on the sample channel, one per beat, and a
// frame is grid_rows by grid_cols samples. For every window_size square that
// fits in the frame the block forms the square's sum, and it keeps the largest
// sum together with the number of squares that reach it. One result beat with
// max_sum and tie_count leaves on the output channel for each frame.
// The configuration channel writes grid_rows, grid_cols and window_size by
// index; every write to one of them restarts the frame. The user must write them
// only while no samples are in flight; the block does not enforce it. Register
// values out of range are clamped. A sample beat can be accepted in every cycle
// while sample ready is high, as the running horizontal sum and the best sum
// tracker each close a loop through their own registers and each line memory
// takes one write per cycle. A frame's result is registered through the memory,
// horizontal sum and best sum stages into an eight entry queue; when queued
// results plus samples in flight fill it, sample ready drops until the receiver
// takes a result. Reset sets all three registers to one and starts a fresh
// frame. The line memories are not cleared: every entry is written before it is read.
module max_window_sum_counter #(
  parameter int MAX_COLS = mwsc_pkg::DEF_MAX_COLS,
  parameter int MAX_WINDOW = mwsc_pkg::DEF_MAX_WINDOW,
  parameter int MAX_ROWS = mwsc_pkg::DEF_MAX_ROWS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [mwsc_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mwsc_pkg::SUM_W-1:0]    max_sum,
  output logic [mwsc_pkg::COUNT_W-1:0]         tie_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mwsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mwsc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import mwsc_pkg::*;

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int COLS_N_W = $clog2(MAX_COLS + 1);
  localparam int ROWS_N_W = $clog2(MAX_ROWS + 1);
  localparam int WIN_N_W = $clog2(MAX_WINDOW + 1);
  localparam int RING_DEPTH = MAX_WINDOW * (1 << COL_W);
  localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

  // Configuration registers and their clamped values.
  logic [ROWS_REG_W-1:0] grid_rows;
  logic [COLS_REG_W-1:0] grid_cols;
  logic [WIN_REG_W-1:0] window_size;
  logic [ROWS_N_W-1:0] rows_n;
  logic [COLS_N_W-1:0] cols_n;
  logic [WIN_N_W-1:0] win_n;
  logic [ROW_W-1:0] rows_last;
  logic [COL_W-1:0] cols_last;
  logic [SLOT_W-1:0] slot_last;
  logic cfg_write;
  logic cfg_restart;

  // Position of the next sample.
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_pos;
  logic [SLOT_W-1:0] srow;
  logic [COL_W-1:0] col_back;
  logic [RING_AW-1:0] ring_addr;
  logic accept;

  // First stage: memory data returns.
  logic s1_valid;
  logic signed [SAMPLE_W-1:0] s1_sample;
  logic [COL_W-1:0] s1_col;
  logic s1_r_gt0;
  logic s1_r_ge_w;
  logic s1_c_ge_w;
  logic s1_c0;
  logic s1_win;
  logic s1_last;
  logic s1_hit_up;
  logic s1_hit_w;
  logic [SAMPLE_W-1:0] sold_q;
  logic [SUM_W-1:0] vup_q;
  logic [SUM_W-1:0] vw_q;
  logic [SUM_W-1:0] last_v;
  logic [SUM_W-1:0] v_up;
  logic [SUM_W-1:0] s_old;
  logic [SUM_W-1:0] samp_ext;
  logic [SUM_W-1:0] v_new;
  logic [SUM_W-1:0] v_w;

  // Second stage: running horizontal sum.
  logic s2_valid;
  logic [SUM_W-1:0] s2_v;
  logic [SUM_W-1:0] s2_vw;
  logic s2_c0;
  logic s2_win;
  logic s2_last;
  logic [SUM_W-1:0] h_sum;
  logic [SUM_W-1:0] h_next;

  // Third stage: best sum tracking.
  logic s3_valid;
  logic s3_win;
  logic s3_last;
  logic signed [SUM_W-1:0] best_sum;
  logic [COUNT_W-1:0] best_count;
  logic seen;
  logic signed [SUM_W-1:0] best_sum_next;
  logic [COUNT_W-1:0] best_count_next;
  logic seen_next;
  logic push;
  result_t push_data;
  result_t head;
  logic [LEVEL_W-1:0] q_level;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;
  assign cfg_restart = cfg_write && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS
                                     || cfg_index == REG_WINDOW_SIZE);

  always_comb begin
    if (grid_rows == '0) begin
      rows_n = ROWS_N_W'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      rows_n = ROWS_N_W'(MAX_ROWS);
    end else begin
      rows_n = ROWS_N_W'(grid_rows);
    end
    if (grid_cols == '0) begin
      cols_n = COLS_N_W'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      cols_n = COLS_N_W'(MAX_COLS);
    end else begin
      cols_n = COLS_N_W'(grid_cols);
    end
    if (window_size == '0) begin
      win_n = WIN_N_W'(1);
    end else if (32'(window_size) > MAX_WINDOW) begin
      win_n = WIN_N_W'(MAX_WINDOW);
    end else begin
      win_n = WIN_N_W'(window_size);
    end
  end

  assign rows_last = ROW_W'(rows_n - ROWS_N_W'(1));
  assign cols_last = COL_W'(cols_n - COLS_N_W'(1));
  assign slot_last = SLOT_W'(win_n - WIN_N_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= ROWS_REG_W'(1);
      grid_cols <= COLS_REG_W'(1);
      window_size <= WIN_REG_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_ROWS: begin
          grid_rows <= cfg_data[ROWS_REG_W-1:0];
        end
        REG_GRID_COLS: begin
          grid_cols <= cfg_data[COLS_REG_W-1:0];
        end
        REG_WINDOW_SIZE: begin
          window_size <= cfg_data[WIN_REG_W-1:0];
        end
        default: begin
          grid_rows <= grid_rows;
        end
      endcase
    end
  end

  // Credit check: every sample in flight may still end a frame.
  assign in_ready = (32'(q_level) + 32'(s1_valid) + 32'(s2_valid) + 32'(s3_valid))
                    < QUEUE_DEPTH;
  assign accept = in_valid && in_ready;

  assign col_back = COL_W'(32'(col_pos) - 32'(win_n));
  assign ring_addr = RING_AW'({srow, col_pos});

  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      srow <= '0;
    end else if (cfg_restart) begin
      row_pos <= '0;
      col_pos <= '0;
      srow <= '0;
    end else if (accept) begin
      if (col_pos == cols_last) begin
        col_pos <= '0;
        if (row_pos == rows_last) begin
          row_pos <= '0;
          srow <= '0;
        end else begin
          row_pos <= row_pos + 1'b1;
          srow <= (srow == slot_last) ? '0 : srow + 1'b1;
        end
      end else begin
        col_pos <= col_pos + 1'b1;
      end
    end
  end

  // The sample ring holds the last window_size rows of samples.
  mwsc_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(RING_DEPTH)
  ) u_sample_ring (
    .clk  (clk),
    .we   (accept),
    .waddr(ring_addr),
    .wdata(sample),
    .raddr(ring_addr),
    .rdata(sold_q)
  );

  // Two copies of the column sum line, one for each read address.
  mwsc_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_COLS)
  ) u_col_up (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(v_new),
    .raddr(col_pos),
    .rdata(vup_q)
  );

  mwsc_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_COLS)
  ) u_col_back (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(v_new),
    .raddr(col_back),
    .rdata(vw_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_sample <= sample;
      s1_col <= col_pos;
      s1_r_gt0 <= (row_pos != '0);
      s1_r_ge_w <= (32'(row_pos) >= 32'(win_n));
      s1_c_ge_w <= (32'(col_pos) >= 32'(win_n));
      s1_c0 <= (col_pos == '0);
      s1_win <= (32'(row_pos) + 1 >= 32'(win_n)) && (32'(col_pos) + 1 >= 32'(win_n));
      s1_last <= (col_pos == cols_last) && (row_pos == rows_last);
      // The column sum written in this cycle is not yet visible at the read port.
      s1_hit_up <= s1_valid && (s1_col == col_pos);
      s1_hit_w <= s1_valid && (s1_col == col_back);
    end
  end

  assign samp_ext = {{(SUM_W - SAMPLE_W){s1_sample[SAMPLE_W-1]}}, s1_sample};
  assign s_old = s1_r_ge_w ? {{(SUM_W - SAMPLE_W){sold_q[SAMPLE_W-1]}}, sold_q} : '0;
  assign v_up = s1_r_gt0 ? (s1_hit_up ? last_v : vup_q) : '0;
  assign v_w = s1_c_ge_w ? (s1_hit_w ? last_v : vw_q) : '0;
  assign v_new = v_up + samp_ext - s_old;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      last_v <= v_new;
      s2_v <= v_new;
      s2_vw <= v_w;
      s2_c0 <= s1_c0;
      s2_win <= s1_win;
      s2_last <= s1_last;
    end
  end

  assign h_next = (s2_c0 ? '0 : h_sum) + s2_v - s2_vw;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    if (s2_valid) begin
      h_sum <= h_next;
      s3_win <= s2_win;
      s3_last <= s2_last;
    end
  end

  always_comb begin
    best_sum_next = best_sum;
    best_count_next = best_count;
    seen_next = seen;
    if (s3_valid && s3_win) begin
      if (!seen || $signed(h_sum) > best_sum) begin
        best_sum_next = $signed(h_sum);
        best_count_next = COUNT_W'(1);
        seen_next = 1'b1;
      end else if ($signed(h_sum) == best_sum && best_count != COUNT_MAX) begin
        best_count_next = best_count + 1'b1;
      end
    end
  end

  assign push = s3_valid && s3_last;
  assign push_data = '{max_sum: best_sum_next, tie_count: best_count_next};

  always_ff @(posedge clk) begin
    if (rst || cfg_restart || push) begin
      best_sum <= '0;
      best_count <= '0;
      seen <= 1'b0;
    end else begin
      best_sum <= best_sum_next;
      best_count <= best_count_next;
      seen <= seen_next;
    end
  end

  mwsc_result_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .head_valid(out_valid),
    .head_ready(out_ready),
    .head      (head),
    .level     (q_level)
  );

  assign max_sum = head.max_sum;
  assign tie_count = head.tie_count;

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (q_level < LEVEL_W'(QUEUE_DEPTH)))
    else $error("Result beat pushed into a full queue.");

  a_count_seen: assert property (@(posedge clk) disable iff (rst)
    !seen |-> (best_count == '0))
    else $error("Tie count is nonzero before any window was seen.");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == REG_GRID_ROWS || cfg_index == REG_GRID_COLS
     || cfg_index == REG_WINDOW_SIZE)) |=> (row_pos == '0 && col_pos == '0))
    else $error("Frame position did not restart after a register write.");

  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tie_count == '0) |-> (max_sum == '0))
    else $error("Frame without a window reports a nonzero sum.");

endmodule

### sv/mwsc_ram.sv
// Generic single-write, single-read memory with a registered read port.
`timescale 1ns / 1ps

module mwsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/mwsc_result_queue.sv
// Small queue that holds finished frame results until the receiver takes them.
`timescale 1ns / 1ps

module mwsc_result_queue #(
  parameter int DEPTH = mwsc_pkg::QUEUE_DEPTH,
  localparam int LEVEL_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mwsc_pkg::result_t    push_data,
  output logic                 head_valid,
  input  logic                 head_ready,
  output mwsc_pkg::result_t    head,
  output logic [LEVEL_W-1:0]   level
);

  import mwsc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  result_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic pop;

  assign head_valid = (level != '0);
  assign pop = head_valid && head_ready;
  assign head = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10: begin
          level <= level + 1'b1;
        end
        2'b01: begin
          level <= level - 1'b1;
        end
        default: begin
          level <= level;
        end
      endcase
    end
  end

endmodule

### test/mwsc_checker.sv
// Checker for the max window sum counter: predicts each frame result and compares result beats.
`timescale 1ns / 1ps

module mwsc_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [mwsc_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [mwsc_pkg::SUM_W-1:0]    max_sum,
  input  logic [mwsc_pkg::COUNT_W-1:0]         tie_count,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [mwsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [mwsc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   error_count,
  output int                                   pending_count
);
  import mwsc_pkg::*;

  logic [ROWS_REG_W-1:0] rows_reg;
  logic [COLS_REG_W-1:0] cols_reg;
  logic [WIN_REG_W-1:0] win_reg;

  longint prefix_mem [0:DEF_MAX_WINDOW][0:DEF_MAX_COLS-1];
  int unsigned row_pos;
  int unsigned col_pos;
  longint best_sum;
  logic [COUNT_W-1:0] best_count;
  bit window_seen;

  result_t frame_results_q[$];

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_frame();
    row_pos = 0;
    col_pos = 0;
    best_sum = 0;
    best_count = '0;
    window_seen = 1'b0;
  endfunction

  task automatic accumulate_sample(input logic signed [SAMPLE_W-1:0] smp);
    int unsigned nrows, ncols, w, r, c, slot, prev, top;
    longint left, up, upleft, p, wsum;
    result_t res;
    nrows = clamp_to(rows_reg, DEF_MAX_ROWS);
    ncols = clamp_to(cols_reg, DEF_MAX_COLS);
    w = clamp_to(win_reg, DEF_MAX_WINDOW);
    r = row_pos;
    c = col_pos;
    if (r >= nrows || c >= ncols) begin
      r = 0;
      c = 0;
    end
    slot = r % (w + 1);
    prev = (slot == 0) ? w : slot - 1;
    top = (slot + 1) % (w + 1);

    // Prefix reads above the first row or left of the first column count as zero.
    left = (c > 0) ? prefix_mem[slot][c-1] : 0;
    up = (r > 0) ? prefix_mem[prev][c] : 0;
    upleft = (r > 0 && c > 0) ? prefix_mem[prev][c-1] : 0;
    p = longint'(smp) + up + left - upleft;
    prefix_mem[slot][c] = p;

    if (r + 1 >= w && c + 1 >= w) begin
      wsum = p;
      if (r >= w) wsum -= prefix_mem[top][c];
      if (c >= w) wsum -= prefix_mem[slot][c-w];
      if (r >= w && c >= w) wsum += prefix_mem[top][c-w];
      if (!window_seen || wsum > best_sum) begin
        best_sum = wsum;
        best_count = COUNT_W'(1);
        window_seen = 1'b1;
      end else if (wsum == best_sum && best_count != COUNT_MAX) begin
        best_count = best_count + 1'b1;
      end
    end

    if (c + 1 < ncols) begin
      col_pos = c + 1;
      row_pos = r;
    end else begin
      col_pos = 0;
      if (r + 1 < nrows) begin
        row_pos = r + 1;
      end else begin
        res.max_sum = best_sum[SUM_W-1:0];
        res.tie_count = best_count;
        frame_results_q.push_back(res);
        restart_frame();
      end
    end
  endtask

  always @(posedge clk) begin : watch
    result_t exp_res;
    if (rst) begin
      rows_reg = ROWS_REG_W'(1);
      cols_reg = COLS_REG_W'(1);
      win_reg = WIN_REG_W'(1);
      restart_frame();
      frame_results_q.delete();
      error_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (frame_results_q.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat, got max_sum %0d tie_count %0d",
                   $time, max_sum, tie_count);
        end else begin
          exp_res = frame_results_q.pop_front();
          if (max_sum !== exp_res.max_sum) begin
            error_count++;
            $display("%0t: max_sum expected %0d, got %0d", $time, exp_res.max_sum, max_sum);
          end
          if (tie_count !== exp_res.tie_count) begin
            error_count++;
            $display("%0t: tie_count expected %0d, got %0d",
                     $time, exp_res.tie_count, tie_count);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GRID_ROWS: begin
            rows_reg = cfg_data[ROWS_REG_W-1:0];
            restart_frame();
          end
          REG_GRID_COLS: begin
            cols_reg = cfg_data[COLS_REG_W-1:0];
            restart_frame();
          end
          REG_WINDOW_SIZE: begin
            win_reg = cfg_data[WIN_REG_W-1:0];
            restart_frame();
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) accumulate_sample(sample);
    end
    pending_count = frame_results_q.size();
  end

endmodule

### test/tb_max_window_sum_counter.sv
// Testbench top for the max window sum counter: drives frames and register writes, gives the verdict.
`timescale 1ns / 1ps

module tb_max_window_sum_counter;
  import mwsc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int TOTAL_ITEMS = 1750;
  localparam int QUIET_ITEMS = 300;

  typedef enum {FILL_RANDOM, FILL_SMALL, FILL_HIGH, FILL_LOW, FILL_EDGES} fill_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SUM_W-1:0] max_sum;
  logic [COUNT_W-1:0] tie_count;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int error_count;
  int pending_count;

  bit quiet_tail;
  bit gaps_on;
  bit counting;
  int sent_items;
  int stall_left = 0;
  int unsigned cur_rows;
  int unsigned cur_cols;

  max_window_sum_counter DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .max_sum(max_sum),
    .tie_count(tie_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  mwsc_checker checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .max_sum(max_sum),
    .tie_count(tie_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .error_count(error_count),
    .pending_count(pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** max_window_sum_counter: FAILED **");
    $finish;
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (!quiet_tail && gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int unsigned frame_len();
    int unsigned r, c;
    r = (cur_rows == 0) ? 1 : (cur_rows > DEF_MAX_ROWS) ? DEF_MAX_ROWS : cur_rows;
    c = (cur_cols == 0) ? 1 : (cur_cols > DEF_MAX_COLS) ? DEF_MAX_COLS : cur_cols;
    return r * c;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(fill_t f);
    logic signed [SAMPLE_W-1:0] v;
    case (f)
      FILL_SMALL: v = 16'($urandom_range(0, 4)) - 16'd2;
      FILL_HIGH: v = 16'sh7FFF;
      FILL_LOW: v = 16'sh8000;
      FILL_EDGES: begin
        case ($urandom_range(0, 3))
          0: v = 16'sh7FFF;
          1: v = 16'sh8000;
          2: v = 16'sh0000;
          default: v = 16'shFFFF;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  task automatic put_sample(input logic signed [SAMPLE_W-1:0] v);
    if (!quiet_tail && gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= v;
    do @(posedge clk); while (!in_ready);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic feed(input fill_t f, input int unsigned n);
    repeat (n) begin
      put_sample(pick_sample(f));
    end
  endtask

  // Holds the sample channel until every frame result has left, then lets the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] c,
                           input logic [CFG_DATA_W-1:0] w);
    settle();
    write_reg(REG_GRID_ROWS, r);
    write_reg(REG_GRID_COLS, c);
    write_reg(REG_WINDOW_SIZE, w);
    cfg_valid <= 1'b0;
    cur_rows = r;
    cur_cols = c[COLS_REG_W-1:0];
  endtask

  initial begin
    int unsigned nr, nc, nw, len, part;
    int phase, nframes;
    fill_t fill;
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_GRID_ROWS;
    cfg_data = '0;
    quiet_tail = 1'b0;
    gaps_on = 1'b1;
    counting = 1'b0;
    sent_items = 0;
    cur_rows = 1;
    cur_cols = 1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // One sample frames at the reset setting, then a single window, ties and no window.
    put_sample(16'sh7FFF);
    put_sample(16'sh8000);
    put_sample(16'sh0000);
    put_sample(16'shFFFF);
    put_sample(16'sh0001);
    configure(2, 2, 2);
    feed(FILL_LOW, 4);
    configure(3, 3, 2);
    repeat (9) put_sample(16'sd5);
    configure(2, 2, 3);
    feed(FILL_EDGES, 4);

    phase = 0;
    while (sent_items < TOTAL_ITEMS || phase <= 12) begin
      gaps_on = $urandom_range(0, 3) != 0;
      nframes = 1;
      counting = 1'b0;
      case (phase)
        2: begin
          configure(0, 6, 0);
          fill = FILL_RANDOM;
        end
        4: begin
          configure(1, 13'h07FF, 0);
          fill = FILL_EDGES;
        end
        6: begin
          configure(6, 6, 13'h007F);
          fill = FILL_HIGH;
        end
        8: begin
          configure(8, 8, 8);
          fill = FILL_LOW;
        end
        10: begin
          configure(4, 40, 3);
          fill = FILL_SMALL;
        end
        12: begin
          configure(0, 0, 0);
          fill = FILL_RANDOM;
          nframes = 6;
        end
        default: begin
          nr = $urandom_range(1, 9);
          nc = $urandom_range(1, 9) | ($urandom_range(0, 3) << COLS_REG_W);
          nw = $urandom_range(1, 10) | ($urandom_range(0, 63) << WIN_REG_W);
          fill = fill_t'($urandom_range(0, 4));
          nframes = $urandom_range(1, 4);
          configure(CFG_DATA_W'(nr), CFG_DATA_W'(nc), CFG_DATA_W'(nw));
          counting = 1'b1;
        end
      endcase
      len = frame_len();
      repeat (nframes) feed(fill, len);
      if (counting && len > 1 && $urandom_range(0, 3) == 0) begin
        part = $urandom_range(1, len - 1);
        feed(fill, part);
        // A write to the unused index must leave the frame in progress alone.
        if ($urandom_range(0, 1) == 1) begin
          settle();
          write_reg(REG_SPARE, 13'($urandom));
          cfg_valid <= 1'b0;
          feed(fill, len - part);
        end
      end
      if (sent_items >= TOTAL_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      phase++;
    end

    settle();
    if (error_count == 0 && pending_count == 0) begin
      $display("** max_window_sum_counter: PASSED **");
    end else begin
      $display("** max_window_sum_counter: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
sv/mwsc_pkg.sv
sv/mwsc_ram.sv
sv/mwsc_result_queue.sv
sv/max_window_sum_counter.sv
test/mwsc_checker.sv
test/tb_max_window_sum_counter.sv
